FILE: sv/rcc_pkg.sv
// Shared constants, codes and types of the rolling checksum chunker.
package rcc_pkg;

    localparam int WINDOW_DEF      = 128;
    localparam int OFFSET_BITS_DEF = 48;
    localparam int CHAR_BIAS       = 31;

    localparam int SUM_W      = 16;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int REASON_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // result buffer depth; three or more keeps one byte per cycle under a pop each cycle
    localparam int OUT_DEPTH = 4;

    localparam logic [REASON_W-1:0] REASON_MATCH = 2'd0;
    localparam logic [REASON_W-1:0] REASON_MAX   = 2'd1;
    localparam logic [REASON_W-1:0] REASON_EOS   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MASK = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MIN_LENGTH_RST = 16'd128;
    localparam logic [CFG_DATA_W-1:0] MAX_LENGTH_RST = 16'd20480;
    localparam logic [CFG_DATA_W-1:0] MATCH_MASK_RST = 16'h1fff;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] min_length;
        logic [CFG_DATA_W-1:0] max_length;
        logic [CFG_DATA_W-1:0] match_mask;
    } cfg_t;

endpackage

FILE: sv/rcc_ram.sv
// Generic single-port RAM, read-first, registered read data.
module rcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rcc_roll.sv
// Rolling checksum stage: sum update, boundary decision and chunk bookkeeping.
module rcc_roll #(
    parameter int WINDOW      = rcc_pkg::WINDOW_DEF,
    parameter int OFFSET_BITS = rcc_pkg::OFFSET_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rcc_pkg::cfg_t                     cfg,
    input  logic                              in_accept,
    input  logic [rcc_pkg::BYTE_W-1:0]        in_byte,
    input  logic                              in_eos,
    input  logic [rcc_pkg::BYTE_W-1:0]        rd_data,
    output logic [$clog2(WINDOW)-1:0]         slot_next,
    output logic                              busy,
    output logic                              res_valid,
    output logic [OFFSET_BITS-1:0]            res_offset,
    output logic [rcc_pkg::LEN_W-1:0]         res_length,
    output logic [2*rcc_pkg::SUM_W-1:0]       res_digest,
    output logic [rcc_pkg::REASON_W-1:0]      res_reason
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam logic [rcc_pkg::SUM_W-1:0] SUM_LOW_INIT =
        rcc_pkg::SUM_W'((64'(WINDOW) * rcc_pkg::CHAR_BIAS) % 65536);
    localparam logic [rcc_pkg::SUM_W-1:0] SUM_HIGH_INIT =
        rcc_pkg::SUM_W'((64'(WINDOW) * (WINDOW - 1) * rcc_pkg::CHAR_BIAS) % 65536);
    localparam logic [rcc_pkg::SUM_W-1:0] WIN_16    = rcc_pkg::SUM_W'(WINDOW);
    localparam logic [rcc_pkg::LEN_W-1:0] WIN_LEN   = rcc_pkg::LEN_W'(WINDOW);
    localparam logic [ADDR_W-1:0]         LAST_SLOT = ADDR_W'(WINDOW - 1);

    logic                          st_valid_reg;
    logic [rcc_pkg::BYTE_W-1:0]    st_byte_reg;
    logic                          st_eos_reg;

    logic [rcc_pkg::SUM_W-1:0]     sum_low_reg,  sum_low_next;
    logic [rcc_pkg::SUM_W-1:0]     sum_high_reg, sum_high_next;
    logic [rcc_pkg::LEN_W-1:0]     fill_reg,     fill_next;
    logic [ADDR_W-1:0]             slot_reg;
    logic [OFFSET_BITS-1:0]        start_reg,    start_next;
    logic [OFFSET_BITS-1:0]        pos_reg,      pos_next;

    logic [rcc_pkg::BYTE_W-1:0]    drop;
    logic [rcc_pkg::BYTE_W:0]      drop_bias;
    logic [rcc_pkg::SUM_W-1:0]     drop_term;
    logic [rcc_pkg::SUM_W-1:0]     s1;
    logic [rcc_pkg::SUM_W-1:0]     s2;
    logic [rcc_pkg::LEN_W-1:0]     fill_inc;
    logic [OFFSET_BITS-1:0]        pos_inc;
    logic                          cut_max;
    logic                          cut_match;

    // stage register: the byte read address went out at accept, data lands now
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= in_accept;
        end
        if (in_accept) begin
            st_byte_reg <= in_byte;
            st_eos_reg  <= in_eos;
        end
    end

    // drop only counts once the chunk holds a full window
    assign drop      = (fill_reg >= WIN_LEN) ? rd_data : '0;
    assign drop_bias = {1'b0, drop} + (rcc_pkg::BYTE_W + 1)'(rcc_pkg::CHAR_BIAS);
    assign drop_term = rcc_pkg::SUM_W'(WIN_16 * {{(rcc_pkg::SUM_W - rcc_pkg::BYTE_W - 1){1'b0}},
                                                  drop_bias});
    assign s1        = sum_low_reg + {{(rcc_pkg::SUM_W - rcc_pkg::BYTE_W){1'b0}}, st_byte_reg}
                       - {{(rcc_pkg::SUM_W - rcc_pkg::BYTE_W){1'b0}}, drop};
    assign s2        = sum_high_reg + s1 - drop_term;
    assign fill_inc  = fill_reg + 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign cut_max   = fill_inc >= cfg.max_length;
    assign cut_match = (fill_inc >= cfg.min_length) &&
                       ((s2 & cfg.match_mask) == cfg.match_mask);

    always_comb begin
        sum_low_next  = sum_low_reg;
        sum_high_next = sum_high_reg;
        fill_next     = fill_reg;
        slot_next     = slot_reg;
        start_next    = start_reg;
        pos_next      = pos_reg;
        res_valid     = 1'b0;
        res_offset    = start_reg;
        res_length    = fill_inc;
        res_digest    = {s1, s2};
        res_reason    = rcc_pkg::REASON_MATCH;
        if (st_valid_reg) begin
            if (st_eos_reg) begin
                res_valid     = (fill_reg != '0);
                res_length    = fill_reg;
                res_digest    = {sum_low_reg, sum_high_reg};
                res_reason    = rcc_pkg::REASON_EOS;
                pos_next      = '0;
                start_next    = '0;
                fill_next     = '0;
                slot_next     = '0;
                sum_low_next  = SUM_LOW_INIT;
                sum_high_next = SUM_HIGH_INIT;
            end else if (cut_max || cut_match) begin
                res_valid     = 1'b1;
                res_reason    = cut_max ? rcc_pkg::REASON_MAX : rcc_pkg::REASON_MATCH;
                pos_next      = pos_inc;
                start_next    = pos_inc;
                fill_next     = '0;
                slot_next     = '0;
                sum_low_next  = SUM_LOW_INIT;
                sum_high_next = SUM_HIGH_INIT;
            end else begin
                pos_next      = pos_inc;
                fill_next     = fill_inc;
                slot_next     = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                sum_low_next  = s1;
                sum_high_next = s2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_low_reg  <= SUM_LOW_INIT;
            sum_high_reg <= SUM_HIGH_INIT;
            fill_reg     <= '0;
            slot_reg     <= '0;
            start_reg    <= '0;
            pos_reg      <= '0;
        end else begin
            sum_low_reg  <= sum_low_next;
            sum_high_reg <= sum_high_next;
            fill_reg     <= fill_next;
            slot_reg     <= slot_next;
            start_reg    <= start_next;
            pos_reg      <= pos_next;
        end
    end

    assign busy = st_valid_reg;

endmodule

FILE: sv/rcc_out_fifo.sv
// Small register FIFO that holds finished chunk records for the output side.
module rcc_out_fifo #(
    parameter int WIDTH = 98,
    parameter int DEPTH = rcc_pkg::OUT_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(do_pop);
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: sv/rolling_checksum_chunker_core.sv
// A chunk record passes the stage register, then the result FIFO, to m_tvalid.
// Throughput: one byte or end-of-stream marker per cycle when ready; the window RAM
//   is read at accept, the sum/boundary update one stage, so nothing repeats per item.
// Backpressure: s_tready drops only when the four-entry result FIFO and the stage can
//   hold no more. Reset (aresetn low, synchronous) empties the pipeline and FIFO,
//   restores the registers and starts a fresh stream; the window RAM is not cleared.
module rolling_checksum_chunker_core #(
    parameter int WINDOW      = rcc_pkg::WINDOW_DEF,
    parameter int OFFSET_BITS = rcc_pkg::OFFSET_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rcc_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // end_of_stream
    // chunk record stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chunk_offset, chunk_length, digest from bit 0 up; zero padded to whole bytes
    output logic [((OFFSET_BITS+48+7)/8)*8-1:0] m_tdata,
    output logic [rcc_pkg::REASON_W-1:0]        m_tuser    // end_reason
);

    localparam int ADDR_W  = $clog2(WINDOW);
    localparam int TDATA_W = ((OFFSET_BITS + 48 + 7) / 8) * 8;
    localparam int PAY_W   = OFFSET_BITS + rcc_pkg::LEN_W + 2 * rcc_pkg::SUM_W;
    localparam int REC_W   = PAY_W + rcc_pkg::REASON_W;
    localparam int CNT_W   = $clog2(rcc_pkg::OUT_DEPTH + 1);

    rcc_pkg::cfg_t                   cfg_reg;
    logic                            in_accept;
    logic                            wr_byte;
    logic [ADDR_W-1:0]               slot_next;
    logic [rcc_pkg::BYTE_W-1:0]      rd_data;
    logic                            busy;
    logic                            res_valid;
    logic [OFFSET_BITS-1:0]          res_offset;
    logic [rcc_pkg::LEN_W-1:0]       res_length;
    logic [2*rcc_pkg::SUM_W-1:0]     res_digest;
    logic [rcc_pkg::REASON_W-1:0]    res_reason;
    logic [REC_W-1:0]                rec_in;
    logic [REC_W-1:0]                rec_out;
    logic [CNT_W-1:0]                fifo_count;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_length <= rcc_pkg::MIN_LENGTH_RST;
            cfg_reg.max_length <= rcc_pkg::MAX_LENGTH_RST;
            cfg_reg.match_mask <= rcc_pkg::MATCH_MASK_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rcc_pkg::CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_data;
                rcc_pkg::CFG_MAX_LENGTH: cfg_reg.max_length <= cfg_data;
                rcc_pkg::CFG_MATCH_MASK: cfg_reg.match_mask <= cfg_data;
                default: ;
            endcase
        end
    end

    // Accept while the FIFO can still absorb everything in flight: the stage plus
    // the queued records must stay below the FIFO depth.
    assign s_tready  = ({1'b0, fifo_count} + (CNT_W + 1)'(busy))
                       < (CNT_W + 1)'(rcc_pkg::OUT_DEPTH);
    assign in_accept = s_tvalid && s_tready;
    assign wr_byte   = in_accept && !s_tlast;

    // Window ring: the slot of the incoming byte is read (old byte, WINDOW back)
    // and overwritten in the same cycle. slot_next already accounts for the byte
    // in the stage, including a cut, so no forwarding is needed; a fresh chunk
    // ignores the read data until it holds WINDOW bytes.
    rcc_ram #(
        .WIDTH (rcc_pkg::BYTE_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (wr_byte),
        .addr  (slot_next),
        .wdata (s_tdata),
        .rdata (rd_data)
    );

    rcc_roll #(
        .WINDOW      (WINDOW),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_roll (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .rd_data    (rd_data),
        .slot_next  (slot_next),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_offset (res_offset),
        .res_length (res_length),
        .res_digest (res_digest),
        .res_reason (res_reason)
    );

    assign rec_in = {res_reason, res_digest, res_length, res_offset};

    rcc_out_fifo #(
        .WIDTH (REC_W),
        .DEPTH (rcc_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (rec_in),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (rec_out),
        .count     (fifo_count)
    );

    assign m_tdata = TDATA_W'(rec_out[PAY_W-1:0]);
    assign m_tuser = rec_out[REC_W-1:PAY_W];

endmodule

FILE: sv/rcc_checker.sv
// Port-level assertions for the chunker core, bound to the top level.
module rcc_checker #(
    parameter int OFFSET_BITS = rcc_pkg::OFFSET_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((OFFSET_BITS+48+7)/8)*8-1:0] m_tdata,
    input logic [rcc_pkg::REASON_W-1:0]        m_tuser
);

    // a stalled record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output record changed while stalled");

    // no empty chunk is ever reported
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OFFSET_BITS +: rcc_pkg::LEN_W] != '0)
        else $error("zero length chunk");

    a_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == rcc_pkg::REASON_MATCH || m_tuser == rcc_pkg::REASON_MAX ||
                      m_tuser == rcc_pkg::REASON_EOS))
        else $error("bad end reason");

    // input backpressure only comes from queued output records
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing queued");

    // reset empties the result queue
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("record visible after reset");

endmodule

bind rolling_checksum_chunker_core rcc_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_rcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
